// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the typematic repeat RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_IMPL(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

// ----- rtl/core/krt_pkg.sv -----
// Shared types and constants of the typematic key repeat block.
// No dependencies; imported by the top level, the front and the back.
`timescale 1ns / 1ps

package krt_pkg;

   // input operation codes
   localparam logic [1:0] OP_KEY   = 2'd0;
   localparam logic [1:0] OP_CTRL  = 2'd1;
   localparam logic [1:0] OP_FRAME = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_INITIAL_DELAY   = 2'd0;
   localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd1;
   localparam logic [1:0] REG_DEAD_ZONE       = 2'd2;

   // register reset values
   localparam logic [7:0] RESET_INITIAL_DELAY   = 8'd20;
   localparam logic [7:0] RESET_REPEAT_INTERVAL = 8'd3;
   localparam logic [7:0] RESET_DEAD_ZONE       = 8'd15;

   // controller mapping
   localparam int NUM_PORTS    = 4;
   localparam int NUM_BITS     = 16;
   localparam int BUTTON_LEVEL = 64;
   localparam int STICK_CENTRE = 128;
   localparam int VIRTUAL_BASE = 128;

   // key table entry: press state over repeat countdown
   localparam int PRESS_W = 2;
   localparam int COUNT_W = 16;
   localparam int ENTRY_W = PRESS_W + COUNT_W;

   localparam logic [PRESS_W-1:0] PRESS_IDLE = 2'd0;
   localparam logic [PRESS_W-1:0] PRESS_HELD = 2'd1;
   localparam logic [PRESS_W-1:0] PRESS_SEEN = 2'd2;

   typedef enum logic [1:0] {
      CMD_KEY,
      CMD_CTRL,
      CMD_FRAME
   } cmd_kind_type;

   // work handed from the front to the back
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   code;     // key code, or first virtual code of a port
      logic [15:0]  mask;     // pressed controller bits
      logic [7:0]   elapsed;  // frames to age the table by
   } cmd_type;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// ----- rtl/core/key_repeat_typematic.sv -----
// Top level of the typematic key repeat block: configuration registers,
// front end, command queue, back end and result queue.
// Depends on krt_pkg, krt_front, krt_fifo and krt_back.
//
// Usage:
// Input items enter as a queue: an item is taken at a clock edge with push
// high and full low. op selects a key report, a controller report or an end
// of frame. Results leave as a queue: the oldest code sits on rsp_* while
// empty is low and is taken with pop; rsp_last marks the final code of an
// item. Items that produce nothing leave no result.
// Flow: the front classifies an item in the cycle it is taken and queues it
// (two commands deep). The back runs each key in the table RAM as a read,
// then an update: a key report visits one entry, a controller report one
// per pressed bit, an end of frame every one of the NUM_KEYS entries.
// The key table has a single RAM port pair.
// Reset: the back clears the key table, one entry per cycle; full stays
// high meanwhile. Registers return to 20, 3 and 15.
// Stall: when pop stays low the result queue fills, the back holds its entry,
// the command queue fills and full rises.
`timescale 1ns / 1ps

module key_repeat_typematic #(
   parameter int NUM_KEYS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_key_code,
   input  logic [1:0]  req_port,
   input  logic [15:0] req_buttons,
   input  logic [7:0]  req_right_trigger,
   input  logic [7:0]  req_left_trigger,
   input  logic [7:0]  req_stick_x,
   input  logic [7:0]  req_stick_y,
   input  logic [7:0]  req_elapsed_frames,
   // result items
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_emitted_code,
   output logic        rsp_last,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import krt_pkg::*;

   logic [7:0]      initial_delay_ff, repeat_interval_ff, dead_zone_ff;
   logic [1:0]      reg_index;
   logic            csr_write;

   cmd_type         front_cmd, back_cmd;
   logic            front_valid, cmd_full, cmd_empty, cmd_pop;
   logic [$bits(cmd_type)-1:0] cmd_rdata;

   rsp_type         back_item, rsp_item;
   logic            out_push, out_full;
   logic [$bits(rsp_type)-1:0] rsp_rdata;

   back_status_type back_status;

   // configuration registers
   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_delay_ff   <= RESET_INITIAL_DELAY;
         repeat_interval_ff <= RESET_REPEAT_INTERVAL;
         dead_zone_ff       <= RESET_DEAD_ZONE;
      end else if (csr_write) begin
         case (reg_index)
            REG_INITIAL_DELAY:   initial_delay_ff   <= pwdata[7:0];
            REG_REPEAT_INTERVAL: repeat_interval_ff <= pwdata[7:0];
            REG_DEAD_ZONE:       dead_zone_ff       <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_INITIAL_DELAY:   prdata = {24'd0, initial_delay_ff};
         REG_REPEAT_INTERVAL: prdata = {24'd0, repeat_interval_ff};
         REG_DEAD_ZONE:       prdata = {24'd0, dead_zone_ff};
         default:             prdata = '0;
      endcase
   end

   // classify items
   krt_front #(
      .NUM_KEYS (NUM_KEYS)
   ) u_front (
      .op             (req_op),
      .key_code       (req_key_code),
      .port           (req_port),
      .buttons        (req_buttons),
      .right_trigger  (req_right_trigger),
      .left_trigger   (req_left_trigger),
      .stick_x        (req_stick_x),
      .stick_y        (req_stick_y),
      .elapsed_frames (req_elapsed_frames),
      .dead_zone      (dead_zone_ff),
      .cmd            (front_cmd),
      .cmd_valid      (front_valid)
   );

   // hold off items while the table is cleared
   assign full = cmd_full || back_status.clearing;

   krt_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push && !full && front_valid),
      .wdata (front_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   assign back_cmd = cmd_type'(cmd_rdata);

   krt_back #(
      .NUM_KEYS (NUM_KEYS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd             (back_cmd),
      .cmd_valid       (!cmd_empty),
      .cmd_pop         (cmd_pop),
      .initial_delay   (initial_delay_ff),
      .repeat_interval (repeat_interval_ff),
      .out_full        (out_full),
      .out_push        (out_push),
      .out_item        (back_item),
      .status          (back_status)
   );

   krt_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (4)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_item),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign rsp_item         = rsp_type'(rsp_rdata);
   assign rsp_emitted_code = rsp_item.code;
   assign rsp_last         = rsp_item.last;

endmodule

// ----- rtl/core/krt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module krt_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/core/krt_fifo.sv -----
// Small register queue used for commands and for result items.
// No dependencies; DEPTH must be a power of two.
`timescale 1ns / 1ps

module krt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ff];

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
      end
   end

   // hold item data
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/core/krt_front.sv -----
// Front end: classifies an input item into a key, controller or frame command.
// Depends on krt_pkg.
`timescale 1ns / 1ps

module krt_front #(
   parameter int NUM_KEYS = 256
) (
   input  logic            [1:0]  op,
   input  logic            [7:0]  key_code,
   input  logic            [1:0]  port,
   input  logic            [15:0] buttons,
   input  logic            [7:0]  right_trigger,
   input  logic            [7:0]  left_trigger,
   input  logic            [7:0]  stick_x,
   input  logic            [7:0]  stick_y,
   input  logic            [7:0]  elapsed_frames,
   input  logic            [7:0]  dead_zone,
   output krt_pkg::cmd_type       cmd,
   output logic                   cmd_valid
);

   import krt_pkg::*;

   logic signed [9:0]  level [NUM_BITS];
   logic signed [9:0]  threshold;
   logic [NUM_BITS-1:0] pressed;
   logic               port_ok;

   assign threshold = $signed({2'b00, dead_zone});
   assign port_ok   = (int'(port) < NUM_PORTS);

   // controller levels: active-low buttons, triggers and stick halves
   always_comb begin
      for (int i = 0; i < NUM_BITS; i++) begin
         level[i] = buttons[i] ? 10'sd0 : 10'(BUTTON_LEVEL);
      end
      level[0]  = $signed({2'b00, right_trigger});
      level[11] = $signed({2'b00, left_trigger});
      level[12] = $signed(10'(STICK_CENTRE) - {2'b00, stick_y});
      level[13] = $signed({2'b00, stick_y} - 10'(STICK_CENTRE));
      level[14] = $signed(10'(STICK_CENTRE) - {2'b00, stick_x});
      level[15] = $signed({2'b00, stick_x} - 10'(STICK_CENTRE));
   end

   // drop bits below the dead zone or past the key table
   always_comb begin
      for (int i = 0; i < NUM_BITS; i++) begin
         pressed[i] = (level[i] > threshold) &&
                      ((VIRTUAL_BASE + int'(port) * NUM_BITS + i) < NUM_KEYS);
      end
   end

   // build the command; items with no work are dropped here
   always_comb begin
      cmd.kind    = CMD_KEY;
      cmd.code    = key_code;
      cmd.mask    = pressed;
      cmd.elapsed = elapsed_frames;
      cmd_valid   = 1'b0;
      case (op)
         OP_KEY: begin
            cmd_valid = (key_code != 8'd0) && (int'(key_code) < NUM_KEYS);
         end
         OP_CTRL: begin
            cmd.kind  = CMD_CTRL;
            cmd.code  = 8'(VIRTUAL_BASE + int'(port) * NUM_BITS);
            cmd_valid = port_ok && (pressed != '0);
         end
         OP_FRAME: begin
            cmd.kind  = CMD_FRAME;
            cmd_valid = 1'b1;
         end
         default: begin
            cmd_valid = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/core/krt_back.sv -----
// Back end: sequencer over the key table RAM that runs one command at a time.
// Depends on krt_pkg, krt_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krt_back #(
   parameter int NUM_KEYS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  krt_pkg::cmd_type         cmd,
   input  logic                     cmd_valid,
   output logic                     cmd_pop,
   input  logic [7:0]               initial_delay,
   input  logic [7:0]               repeat_interval,
   input  logic                     out_full,
   output logic                     out_push,
   output krt_pkg::rsp_type         out_item,
   output krt_pkg::back_status_type status
);

   import krt_pkg::*;

   localparam int AW = $clog2(NUM_KEYS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_FLUSH
   } state_type;

   state_type          state_ff, state_in;
   cmd_kind_type       kind_ff, kind_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [7:0]         code_ff, code_in;
   logic [7:0]         base_ff, base_in;
   logic [15:0]        mask_ff, mask_in;
   logic [7:0]         elapsed_ff, elapsed_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [7:0]         pend_code_ff, pend_code_in;

   logic               ram_we;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic [PRESS_W-1:0]       prev;
   logic signed [COUNT_W-1:0] count;
   logic signed [COUNT_W:0]  count_up, count_down;
   logic               count_pos, emit;
   logic [3:0]         first_idx;

   function automatic logic [3:0] lowest_bit(input logic [15:0] m);
      logic [3:0] idx;
      idx = '0;
      for (int i = 15; i >= 0; i--) begin
         if (m[i]) idx = 4'(i);
      end
      return idx;
   endfunction

   function automatic logic [COUNT_W-1:0] sat16(input logic signed [COUNT_W:0] v);
      if (v > 17'sd32767) begin
         return 16'h7fff;
      end else if (v < -17'sd32768) begin
         return 16'h8000;
      end else begin
         return v[COUNT_W-1:0];
      end
   endfunction

   krt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_KEYS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // decode the entry read for the current key
   assign prev       = ram_rdata[ENTRY_W-1 -: PRESS_W];
   assign count      = $signed(ram_rdata[COUNT_W-1:0]);
   assign count_up   = {count[COUNT_W-1], count} + $signed({9'd0, repeat_interval});
   assign count_down = {count[COUNT_W-1], count} - $signed({9'd0, elapsed_ff});
   assign count_pos  = !count[COUNT_W-1] && (count != '0);
   assign emit       = (prev == PRESS_IDLE) || !count_pos;

   assign status.clearing = (state_ff == ST_CLEAR);

   // clear the table after reset; per command read an entry, update it, emit if due
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      code_in       = code_ff;
      base_in       = base_ff;
      mask_in       = mask_ff;
      elapsed_in    = elapsed_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      ram_we        = 1'b0;
      ram_wdata     = ram_rdata;
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      out_item.code = pend_code_ff;
      out_item.last = 1'b0;
      first_idx     = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (addr_ff == AW'(NUM_KEYS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               kind_in    = cmd.kind;
               elapsed_in = cmd.elapsed;
               base_in    = cmd.code;
               state_in   = ST_READ;
               case (cmd.kind)
                  CMD_KEY: begin
                     code_in = cmd.code;
                     mask_in = '0;
                     addr_in = AW'(cmd.code);
                  end
                  CMD_CTRL: begin
                     first_idx = lowest_bit(cmd.mask);
                     code_in   = cmd.code + {4'd0, first_idx};
                     mask_in   = cmd.mask & ~(16'd1 << first_idx);
                     addr_in   = AW'(code_in);
                  end
                  default: begin
                     mask_in = '0;
                     addr_in = '0;
                  end
               endcase
            end
         end

         ST_READ: begin
            state_in = ST_UPDATE;
         end

         ST_UPDATE: begin
            if (kind_ff == CMD_FRAME) begin
               // age the entry: held goes idle, seen goes held and counts down
               ram_we = 1'b1;
               case (prev)
                  PRESS_HELD: ram_wdata = {PRESS_IDLE, count};
                  PRESS_SEEN: ram_wdata = {PRESS_HELD,
                                           count_pos ? sat16(count_down) : count};
                  default:    ram_wdata = ram_rdata;
               endcase
               if (addr_ff == AW'(NUM_KEYS - 1)) begin
                  addr_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else if (!(emit && pend_valid_ff && out_full)) begin
               // mark seen, reload or extend the countdown on emission
               ram_we = 1'b1;
               if (!emit) begin
                  ram_wdata = {PRESS_SEEN, count};
               end else if (prev != PRESS_IDLE) begin
                  ram_wdata = {PRESS_SEEN, sat16(count_up)};
               end else begin
                  ram_wdata = {PRESS_SEEN, 8'd0, initial_delay};
               end
               if (emit) begin
                  out_push      = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_code_in  = code_ff;
               end
               if (mask_ff != '0) begin
                  first_idx = lowest_bit(mask_ff);
                  code_in   = base_ff + {4'd0, first_idx};
                  mask_in   = mask_ff & ~(16'd1 << first_idx);
                  addr_in   = AW'(code_in);
                  state_in  = ST_READ;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            // send the held item as the final one of this command
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!out_full) begin
               out_push      = 1'b1;
               out_item.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         pend_valid_ff <= pend_valid_in;
      end
      kind_ff      <= kind_in;
      code_ff      <= code_in;
      base_ff      <= base_in;
      mask_ff      <= mask_in;
      elapsed_ff   <= elapsed_in;
      pend_code_ff <= pend_code_in;
   end

   `ASSERT_NEVER(a_table_quiet_idle, (state_ff == ST_IDLE) && ram_we, "table written while idle")
   `ASSERT_IMPL(a_push_space, out_push |-> !out_full, "result pushed into a full queue")
   `ASSERT_IMPL(a_pop_idle, cmd_pop |-> ((state_ff == ST_IDLE) && cmd_valid), "command taken while busy")
   `ASSERT_IMPL(a_idle_flushed, (state_ff == ST_IDLE) |-> !pend_valid_ff, "result left behind at idle")

endmodule

// ----- tb/sv/tb_key_repeat_typematic.sv -----
`timescale 1ns / 1ps
// Self-checking bench for key_repeat_typematic: a directed table, then random key,
// controller and frame items checked against a local model of the key table.
// Depends on krt_pkg and the key_repeat_typematic RTL.

module tb_key_repeat_typematic;
   import krt_pkg::*;

   localparam int KEY_TABLE_SIZE = 256;
   localparam int MAX_EMIT = 16;
   localparam int SETTLE_CYCLES = 1800;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int NUM_PHASES = 6;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  key_code;
      logic [1:0]  port;
      logic [15:0] buttons;
      logic [7:0]  rt;
      logic [7:0]  lt;
      logic [7:0]  sx;
      logic [7:0]  sy;
      logic [7:0]  el;
   } key_item_type;

   typedef struct {
      key_item_type item;
      bit           typed;
      int           typed_cnt;
      logic [7:0]   typed_code;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_op;
   logic [7:0]  req_key_code;
   logic [1:0]  req_port;
   logic [15:0] req_buttons;
   logic [7:0]  req_right_trigger;
   logic [7:0]  req_left_trigger;
   logic [7:0]  req_stick_x;
   logic [7:0]  req_stick_y;
   logic [7:0]  req_elapsed_frames;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_emitted_code;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // model of the key table and registers
   logic [1:0]         key_press [KEY_TABLE_SIZE];
   logic signed [15:0] key_countdown [KEY_TABLE_SIZE];
   logic [7:0]         cfg_delay;
   logic [7:0]         cfg_interval;
   logic [7:0]         cfg_dead_zone;
   logic [7:0]         emit_codes [$];
   rsp_type            awaited_codes [$];

   stim_row_type directed_rows [$];
   logic [7:0] key_pool [6];
   logic [15:0] button_pool [2];
   int         burst_left;
   int         error_count;
   int         items_taken;
   int         results_seen;

   key_repeat_typematic dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_op(req_op), .req_key_code(req_key_code), .req_port(req_port),
      .req_buttons(req_buttons), .req_right_trigger(req_right_trigger),
      .req_left_trigger(req_left_trigger), .req_stick_x(req_stick_x),
      .req_stick_y(req_stick_y), .req_elapsed_frames(req_elapsed_frames),
      .empty(empty), .pop(pop),
      .rsp_emitted_code(rsp_emitted_code), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic logic signed [15:0] sat16(int v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // one pressed code: emit on a fresh press or an expired countdown
   function automatic void press_key(int unsigned k);
      logic [1:0] prev;
      if (k >= KEY_TABLE_SIZE) return;
      prev = key_press[k];
      key_press[k] = PRESS_SEEN;
      if (prev == PRESS_IDLE || key_countdown[k] <= 0) begin
         if (emit_codes.size() < MAX_EMIT) emit_codes.push_back(k[7:0]);
         if (prev != PRESS_IDLE)
            key_countdown[k] = sat16(int'(key_countdown[k]) + int'(cfg_interval));
         else
            key_countdown[k] = {8'd0, cfg_delay};
      end
   endfunction

   function automatic void scan_controller(key_item_type it);
      int lvl;
      if (int'(it.port) >= NUM_PORTS) return;
      for (int b = 0; b < NUM_BITS; b++) begin
         lvl = it.buttons[b] ? 0 : BUTTON_LEVEL;
         case (b)
            0:  lvl = int'(it.rt);
            11: lvl = int'(it.lt);
            12: lvl = STICK_CENTRE - int'(it.sy);
            13: lvl = int'(it.sy) - STICK_CENTRE;
            14: lvl = STICK_CENTRE - int'(it.sx);
            15: lvl = int'(it.sx) - STICK_CENTRE;
            default: ;
         endcase
         if (lvl > int'(cfg_dead_zone))
            press_key(VIRTUAL_BASE + int'(it.port) * NUM_BITS + b);
      end
   endfunction

   // end of frame: drop stale keys, age held ones, count down
   function automatic void age_table(logic [7:0] el);
      for (int i = 0; i < KEY_TABLE_SIZE; i++) begin
         if (key_press[i] == PRESS_HELD) begin
            key_press[i] = PRESS_IDLE;
         end else if (key_press[i] == PRESS_SEEN) begin
            if (key_countdown[i] > 0)
               key_countdown[i] = sat16(int'(key_countdown[i]) - int'(el));
            key_press[i] = PRESS_HELD;
         end
      end
   endfunction

   function automatic void predict_typematic(key_item_type it);
      emit_codes.delete();
      case (it.op)
         OP_KEY:   if (it.key_code != 8'd0) press_key(int'(it.key_code));
         OP_CTRL:  scan_controller(it);
         OP_FRAME: age_table(it.el);
         default:  ;
      endcase
   endfunction

   function automatic void queue_results();
      for (int i = 0; i < emit_codes.size(); i++)
         awaited_codes.push_back(rsp_type'{code: emit_codes[i],
                                           last: (i == emit_codes.size() - 1)});
   endfunction

   function automatic void reset_model();
      for (int i = 0; i < KEY_TABLE_SIZE; i++) begin
         key_press[i] = PRESS_IDLE;
         key_countdown[i] = '0;
      end
      cfg_delay = RESET_INITIAL_DELAY;
      cfg_interval = RESET_REPEAT_INTERVAL;
      cfg_dead_zone = RESET_DEAD_ZONE;
   endfunction

   function automatic void add_row(logic [1:0] op, logic [7:0] key, logic [1:0] port,
                                   logic [15:0] buttons, logic [7:0] rt, logic [7:0] lt,
                                   logic [7:0] sx, logic [7:0] sy, logic [7:0] el,
                                   bit typed, int cnt, logic [7:0] code);
      stim_row_type row;
      row.item = '{op, key, port, buttons, rt, lt, sx, sy, el};
      row.typed = typed;
      row.typed_cnt = cnt;
      row.typed_code = code;
      directed_rows.push_back(row);
   endfunction

   function automatic bit item_is_ignored(key_item_type it);
      return it.op == OP_UNUSED || (it.op == OP_KEY && it.key_code == 8'd0);
   endfunction

   // mostly keys from a small pool and frames with short ages, so repeats happen
   function automatic key_item_type random_item();
      key_item_type it;
      int pick;
      it = '{2'($urandom), 8'($urandom), 2'($urandom), 16'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         it.op = OP_KEY;
         it.key_code = key_pool[$urandom_range(0, 5)];
      end else if (pick < 50) begin
         it.op = OP_KEY;
      end else if (pick < 75) begin
         it.op = OP_CTRL;
         if ($urandom_range(0, 1)) it.buttons = button_pool[$urandom_range(0, 1)];
         if ($urandom_range(0, 1)) it.sx = 8'(STICK_CENTRE);
         if ($urandom_range(0, 1)) it.sy = 8'(STICK_CENTRE);
      end else if (pick < 97) begin
         it.op = OP_FRAME;
         if ($urandom_range(0, 9) != 0) it.el = 8'($urandom_range(0, 4));
      end else begin
         it.op = OP_UNUSED;
      end
      return it;
   endfunction

   // hand one item over and update the model when it is taken
   task automatic drive_item(key_item_type it);
      @(negedge clock);
      push = 1'b1;
      req_op = it.op;
      req_key_code = it.key_code;
      req_port = it.port;
      req_buttons = it.buttons;
      req_right_trigger = it.rt;
      req_left_trigger = it.lt;
      req_stick_x = it.sx;
      req_stick_y = it.sy;
      req_elapsed_frames = it.el;
      do @(posedge clock); while (full);
      items_taken++;
      predict_typematic(it);
   endtask

   // bursts of random length separated by random gaps
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            push = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // drain every result, then let queued frame sweeps finish
   task automatic wait_idle();
      @(negedge clock);
      push = 1'b0;
      while (awaited_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = {24'd0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_INITIAL_DELAY:   cfg_delay = value;
         REG_REPEAT_INTERVAL: cfg_interval = value;
         REG_DEAD_ZONE:       cfg_dead_zone = value;
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic csr_check(logic [1:0] idx, logic [7:0] want);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {24'd0, want}) report_mismatch("register read", prdata, 32'(want));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic check_all_csrs();
      csr_check(REG_INITIAL_DELAY, cfg_delay);
      csr_check(REG_REPEAT_INTERVAL, cfg_interval);
      csr_check(REG_DEAD_ZONE, cfg_dead_zone);
   endtask

   // receiver: stall pattern that switches between random modes
   initial begin
      int stall_mode;
      int mode_left;
      pop = 1'b0;
      stall_mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         case (stall_mode)
            0: pop = 1'b1;
            1: pop = 1'($urandom_range(0, 1));
            2: pop = ($urandom_range(0, 7) == 0);
            default: pop = (mode_left < 5);
         endcase
      end
   end

   // compare each taken result with the oldest awaited code
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         results_seen++;
         if (awaited_codes.size() == 0) begin
            report_mismatch("result with nothing awaited", 32'(rsp_emitted_code), 0);
         end else begin
            want = awaited_codes.pop_front();
            if (rsp_emitted_code !== want.code)
               report_mismatch("emitted_code", 32'(rsp_emitted_code), 32'(want.code));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   initial begin
      logic [7:0] phase_cfg [NUM_PHASES][3];
      key_item_type it;
      stim_row_type row;
      int taken_in_phase;

      push = 1'b0;
      req_op = OP_KEY;
      req_key_code = '0;
      req_port = '0;
      req_buttons = '0;
      req_right_trigger = '0;
      req_left_trigger = '0;
      req_stick_x = '0;
      req_stick_y = '0;
      req_elapsed_frames = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      error_count = 0;
      items_taken = 0;
      results_seen = 0;
      burst_left = 0;
      reset_model();

      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_all_csrs();

      // directed rows under reset settings
      add_row(OP_KEY, 8'd0, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 0, 0);
      add_row(OP_KEY, 8'd5, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 1, 5);
      add_row(OP_KEY, 8'd5, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 0, 0);
      add_row(OP_KEY, 8'd255, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 1, 255);
      add_row(OP_KEY, 8'd1, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 1, 1);
      add_row(OP_FRAME, 8'd0, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 0, 0);
      add_row(OP_KEY, 8'd5, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 0, 0);
      add_row(OP_FRAME, 8'd0, 0, 16'h0000, 0, 0, 128, 128, 255, 1, 0, 0);
      add_row(OP_KEY, 8'd5, 0, 16'h0000, 0, 0, 128, 128, 0, 0, 0, 0);
      add_row(OP_CTRL, 8'd0, 0, 16'hffff, 0, 0, 128, 128, 0, 1, 0, 0);
      add_row(OP_CTRL, 8'd0, 3, 16'h0000, 255, 255, 0, 255, 0, 0, 0, 0);
      add_row(OP_CTRL, 8'd0, 1, 16'hffff, 0, 0, 255, 0, 0, 0, 0, 0);
      add_row(OP_CTRL, 8'd0, 2, 16'hffff, 16, 15, 128, 128, 0, 1, 1, 160);
      add_row(OP_CTRL, 8'd0, 3, 16'h0000, 255, 255, 0, 255, 0, 0, 0, 0);
      add_row(OP_UNUSED, 8'hff, 3, 16'hffff, 255, 255, 255, 255, 255, 1, 0, 0);
      add_row(OP_FRAME, 8'd0, 0, 16'h0000, 0, 0, 128, 128, 1, 1, 0, 0);
      add_row(OP_FRAME, 8'd0, 0, 16'h0000, 0, 0, 128, 128, 0, 1, 0, 0);
      add_row(OP_KEY, 8'd128, 0, 16'h0000, 0, 0, 128, 128, 0, 0, 0, 0);
      add_row(OP_CTRL, 8'd0, 0, 16'hfffe, 0, 0, 128, 128, 0, 1, 0, 0);
      add_row(OP_KEY, 8'd0, 3, 16'hffff, 255, 255, 255, 255, 255, 1, 0, 0);
      add_row(OP_CTRL, 8'd0, 0, 16'h0000, 255, 255, 0, 0, 0, 0, 0, 0);
      add_row(OP_FRAME, 8'd0, 0, 16'h0000, 0, 0, 128, 128, 2, 0, 0, 0);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         pace_sender();
         drive_item(row.item);
         if (row.typed) begin
            if (emit_codes.size() != row.typed_cnt ||
                (row.typed_cnt == 1 && emit_codes[0] != row.typed_code))
               report_mismatch("table row against model", emit_codes.size(), row.typed_cnt);
            if (row.typed_cnt == 1)
               awaited_codes.push_back(rsp_type'{code: row.typed_code, last: 1'b1});
         end else begin
            queue_results();
         end
      end

      // settings per phase: both extremes, the dead zone at button level, random, reset
      phase_cfg[0] = '{8'd0, 8'd0, 8'd0};
      phase_cfg[1] = '{8'd255, 8'd255, 8'd255};
      phase_cfg[2] = '{8'd1, 8'd1, 8'd64};
      phase_cfg[3] = '{8'($urandom_range(0, 8)), 8'($urandom_range(0, 4)), 8'($urandom)};
      phase_cfg[4] = '{8'($urandom), 8'($urandom), 8'($urandom_range(0, 70))};
      phase_cfg[5] = '{RESET_INITIAL_DELAY, RESET_REPEAT_INTERVAL, RESET_DEAD_ZONE};

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         csr_write(REG_INITIAL_DELAY, phase_cfg[p][0]);
         csr_write(REG_REPEAT_INTERVAL, phase_cfg[p][1]);
         csr_write(REG_DEAD_ZONE, phase_cfg[p][2]);
         check_all_csrs();
         foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(1, 255));
         foreach (button_pool[i]) button_pool[i] = 16'($urandom);
         taken_in_phase = 0;
         while (taken_in_phase < ITEMS_PER_PHASE) begin
            it = random_item();
            pace_sender();
            drive_item(it);
            queue_results();
            if (!item_is_ignored(it)) taken_in_phase++;
         end
      end

      wait_idle();
      $display("covered %0d items over %0d register settings plus reset values",
               items_taken, NUM_PHASES);
      $display("checked %0d emitted codes, %0d mismatches", results_seen, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
